// File: sv/clf_pkg.sv
// Shared types and constants for the command line framer.
`timescale 1ns / 1ps

package clf_pkg;

  localparam int LINE_BYTES_DEFAULT = 256;
  localparam int QUEUE_DEPTH        = 2;

  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] PRINT_LOW  = 8'd32;
  localparam logic [7:0] PRINT_HIGH = 8'd126;

  localparam logic [1:0] KIND_ACCEPTED = 2'd0;
  localparam logic [1:0] KIND_PREFIX   = 2'd1;
  localparam logic [1:0] KIND_BYTE     = 2'd2;

  localparam logic [1:0] VERB_OTHER = 2'd0;
  localparam logic [1:0] VERB_STOP  = 2'd1;
  localparam logic [1:0] VERB_START = 2'd2;

  // Byte class decided at the front
  typedef enum logic [1:0] {
    CLS_NEWLINE = 2'd0,
    CLS_PRINT   = 2'd1,
    CLS_BAD     = 2'd2
  } byte_class_t;

  typedef struct packed {
    byte_class_t cls;
    logic [7:0]  data;
  } q_entry_t;

endpackage

// File: sv/command_line_framer.sv
// Top level of the command line framer.
`timescale 1ns / 1ps

// Frames received serial bytes into newline-terminated command lines.
// Input channel: in_valid / in_stall with in_rx_byte, one byte per transaction.
// Output channel: out_valid / out_stall with the report fields; at most one
// report per byte. Carriage returns are dropped at the front end.
// A byte is classified at the front and held in a two-entry register queue;
// the back end updates the line state and loads the report register.
// A byte is written into a queue register and then loaded into the report
// register before its report is offered.
// Throughput: one byte per cycle while the receiver does not stall a report.
// When the receiver stalls, the held report stays put, the back end stops
// taking bytes from the queue, and once the queue holds two bytes in_stall
// rises until the report is taken.
// Reset (rst_n low, synchronous) empties the queue, drops any pending report
// and clears the line state; bytes are accepted once rst_n is high again.
module command_line_framer #(
  parameter int LINE_BYTES = clf_pkg::LINE_BYTES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_report_kind,
  output logic [1:0]  out_verb_class,
  output logic [31:0] out_request_id,
  output logic [7:0]  out_line_length
);
  import clf_pkg::*;

  logic     push;
  q_entry_t push_entry;
  logic     q_full;
  logic     q_valid;
  logic     q_pop;
  q_entry_t q_entry;

  clf_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  clf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_entry  (q_entry)
  );

  clf_back #(
    .LINE_BYTES (LINE_BYTES)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_entry         (q_entry),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_report_kind (out_report_kind),
    .out_verb_class  (out_verb_class),
    .out_request_id  (out_request_id),
    .out_line_length (out_line_length)
  );

endmodule

// File: sv/clf_front.sv
// Front end: classifies received bytes and pushes them into the queue.
`timescale 1ns / 1ps

module clf_front (
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_rx_byte,
  input  logic              q_full,
  output logic              push,
  output clf_pkg::q_entry_t push_entry
);
  import clf_pkg::*;

  assign in_stall = q_full;

  // Carriage returns are dropped here and never reach the back end
  assign push = in_valid && !q_full && (in_rx_byte != CHAR_CR);

  always_comb begin
    push_entry.data = in_rx_byte;
    if (in_rx_byte == CHAR_LF) begin
      push_entry.cls = CLS_NEWLINE;
    end else if (in_rx_byte < PRINT_LOW || in_rx_byte > PRINT_HIGH) begin
      push_entry.cls = CLS_BAD;
    end else begin
      push_entry.cls = CLS_PRINT;
    end
  end

endmodule

// File: sv/clf_queue.sv
// Short register queue between the front and back ends.
`timescale 1ns / 1ps

module clf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  clf_pkg::q_entry_t push_entry,
  output logic              full,
  output logic              pop_valid,
  input  logic              pop,
  output clf_pkg::q_entry_t pop_entry
);
  import clf_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  q_entry_t        slot_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign full      = (count_r == CW'(QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_entry = slot_r[rd_ptr_r];

  function automatic logic [PW-1:0] bump(logic [PW-1:0] p);
    if (p == PW'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? bump(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? bump(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// File: sv/clf_back.sv
// Back end: line state, prefix check, verb match and the report register.
`timescale 1ns / 1ps

module clf_back #(
  parameter int LINE_BYTES = clf_pkg::LINE_BYTES_DEFAULT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  clf_pkg::q_entry_t q_entry,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_report_kind,
  output logic [1:0]        out_verb_class,
  output logic [31:0]       out_request_id,
  output logic [7:0]        out_line_length
);
  import clf_pkg::*;

  localparam int          CW           = $clog2(LINE_BYTES);
  localparam logic [2:0]  MATCH_FAILED = 3'd7;
  localparam int          TAG_END      = 5;
  localparam int          ID_END       = 13;
  localparam int          MIN_LINE     = 15;
  localparam int          VERB_POS     = 14;

  logic            discarding_r, discarding_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            prefix_good_r, prefix_good_nxt;
  logic [31:0]     id_r, id_nxt;
  logic [2:0]      stop_r, stop_nxt;
  logic [2:0]      start_r, start_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic [1:0]      kind_r, kind_nxt;
  logic [1:0]      verb_r, verb_nxt;
  logic [31:0]     rid_r, rid_nxt;
  logic [7:0]      len_r, len_nxt;

  logic            line_full;
  logic [CW+7:0]   count_wide;
  logic [CW-1:0]   verb_k;
  logic [4:0]      hex;
  logic [7:0]      c;

  function automatic logic [7:0] tag_char(logic [2:0] i);
    unique case (i)
      3'd0:    return 8'h41;
      3'd1:    return 8'h30;
      3'd2:    return 8'h34;
      3'd3:    return 8'h42;
      default: return 8'h20;
    endcase
  endfunction

  function automatic logic [7:0] verb_char(logic is_start, logic [2:0] i);
    if (is_start) begin
      unique case (i)
        3'd0:    return "S";
        3'd1:    return "T";
        3'd2:    return "A";
        3'd3:    return "R";
        default: return "T";
      endcase
    end
    unique case (i)
      3'd0:    return "S";
      3'd1:    return "T";
      3'd2:    return "O";
      default: return "P";
    endcase
  endfunction

  // {ok, value}
  function automatic logic [4:0] hex_digit(logic [7:0] ch);
    if (ch >= "0" && ch <= "9") return {1'b1, 4'(ch - "0")};
    if (ch >= "a" && ch <= "f") return {1'b1, 4'(ch - "a" + 8'd10)};
    if (ch >= "A" && ch <= "F") return {1'b1, 4'(ch - "A" + 8'd10)};
    return 5'd0;
  endfunction

  function automatic logic [2:0] advance(logic [2:0] m, logic [CW-1:0] k,
                                         logic [7:0] ch, logic is_start);
    logic [CW-1:0] len;
    len = is_start ? CW'(5) : CW'(4);
    if ({{(CW-3){1'b0}}, m} == k && k < len && ch == verb_char(is_start, k[2:0])) begin
      return k[2:0] + 3'd1;
    end
    return MATCH_FAILED;
  endfunction

  assign q_pop      = q_valid && (!out_valid_r || !out_stall);
  assign c          = q_entry.data;
  assign line_full  = (count_r >= CW'(LINE_BYTES - 1));
  assign count_wide = {8'd0, count_r};
  assign verb_k     = count_r - CW'(VERB_POS);
  assign hex        = hex_digit(c);

  always_comb begin
    discarding_nxt  = discarding_r;
    count_nxt       = count_r;
    prefix_good_nxt = prefix_good_r;
    id_nxt          = id_r;
    stop_nxt        = stop_r;
    start_nxt       = start_r;

    out_valid_nxt = out_valid_r && out_stall;
    kind_nxt      = kind_r;
    verb_nxt      = verb_r;
    rid_nxt       = rid_r;
    len_nxt       = len_r;

    if (q_pop) begin
      if (q_entry.cls == CLS_NEWLINE) begin
        if (!discarding_r) begin
          out_valid_nxt = 1'b1;
          len_nxt       = count_wide[7:0];
          if (prefix_good_r && count_r >= CW'(MIN_LINE)) begin
            kind_nxt = KIND_ACCEPTED;
            rid_nxt  = id_r;
            priority if (stop_r == 3'd4) begin
              verb_nxt = VERB_STOP;
            end else if (start_r == 3'd5) begin
              verb_nxt = VERB_START;
            end else begin
              verb_nxt = VERB_OTHER;
            end
          end else begin
            kind_nxt = KIND_PREFIX;
            verb_nxt = VERB_OTHER;
            rid_nxt  = '0;
          end
        end
        discarding_nxt  = 1'b0;
        count_nxt       = '0;
        prefix_good_nxt = 1'b1;
        id_nxt          = '0;
        stop_nxt        = '0;
        start_nxt       = '0;
      end else if (q_entry.cls == CLS_BAD || line_full) begin
        // reject the byte and drop the rest of the line
        discarding_nxt = 1'b1;
        out_valid_nxt  = 1'b1;
        kind_nxt       = KIND_BYTE;
        verb_nxt       = VERB_OTHER;
        rid_nxt        = '0;
        len_nxt        = '0;
      end else if (!discarding_r) begin
        priority if (count_r < CW'(TAG_END)) begin
          if (c != tag_char(count_r[2:0])) prefix_good_nxt = 1'b0;
        end else if (count_r < CW'(ID_END)) begin
          if (!hex[4]) begin
            prefix_good_nxt = 1'b0;
          end else begin
            id_nxt = {id_r[27:0], hex[3:0]};
          end
        end else if (count_r == CW'(ID_END)) begin
          if (c != 8'h20) prefix_good_nxt = 1'b0;
        end else begin
          stop_nxt  = advance(stop_r, verb_k, c, 1'b0);
          start_nxt = advance(start_r, verb_k, c, 1'b1);
        end
        count_nxt = count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      discarding_r  <= 1'b0;
      count_r       <= '0;
      prefix_good_r <= 1'b1;
      id_r          <= '0;
      stop_r        <= '0;
      start_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      discarding_r  <= discarding_nxt;
      count_r       <= count_nxt;
      prefix_good_r <= prefix_good_nxt;
      id_r          <= id_nxt;
      stop_r        <= stop_nxt;
      start_r       <= start_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    verb_r <= verb_nxt;
    rid_r  <= rid_nxt;
    len_r  <= len_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_report_kind = kind_r;
  assign out_verb_class  = verb_r;
  assign out_request_id  = rid_r;
  assign out_line_length = len_r;

  a_bad_reports: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && q_entry.cls == CLS_BAD |=> out_valid_r && kind_r == KIND_BYTE)
    else $error("bad byte did not give a byte report");

  a_newline_clears: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && q_entry.cls == CLS_NEWLINE |=> count_r == '0 && !discarding_r)
    else $error("line state not cleared after newline");

  a_verb_only_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && verb_r != VERB_OTHER |-> kind_r == KIND_ACCEPTED)
    else $error("verb class on a rejected report");

  a_no_pop_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !q_pop)
    else $error("queue popped while report held");

endmodule

// File: verif/line_report_checker.sv
// Checker for the command line framer: predicts each report and compares it.
`timescale 1ns / 1ps

module line_report_checker #(
  parameter int LINE_BYTES = clf_pkg::LINE_BYTES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_report_kind,
  input  logic [1:0]  out_verb_class,
  input  logic [31:0] out_request_id,
  input  logic [7:0]  out_line_length,
  output int          fail_count,
  output int          pending_reports
);
  import clf_pkg::*;

  localparam int         MIN_LINE   = 15;
  localparam int         VERB_POS   = 14;
  localparam logic [2:0] MATCH_DEAD = 3'd7;
  localparam logic [7:0] SPACE      = 8'h20;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  verb;
    logic [31:0] id;
    logic [7:0]  len;
  } line_report_t;

  line_report_t awaited_reports[$];
  int           mismatches;

  // Line state
  logic        drop_rest;
  int          stored_len;
  logic        tag_ok;
  logic [31:0] id_acc;
  logic [2:0]  stop_pos;
  logic [2:0]  start_pos;

  string STOP_TEXT  = "STOP";
  string START_TEXT = "START";

  // Five-byte line tag, letter, two digits, letter, space
  function automatic logic [7:0] tag_byte(input int p);
    case (p)
      0: return 8'h41;
      1: return 8'h30;
      2: return 8'h34;
      3: return 8'h42;
      default: return SPACE;
    endcase
  endfunction

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    return -1;
  endfunction

  task automatic new_line();
    drop_rest  = 1'b0;
    stored_len = 0;
    tag_ok     = 1'b1;
    id_acc     = '0;
    stop_pos   = '0;
    start_pos  = '0;
  endtask

  task automatic frame_byte(input logic [7:0] b);
    line_report_t r;
    int           k;
    int           v;
    r = '0;
    if (b == CHAR_CR) return;
    if (b == CHAR_LF) begin
      if (!drop_rest) begin
        r.len = stored_len[7:0];
        if (tag_ok && stored_len >= MIN_LINE) begin
          r.kind = KIND_ACCEPTED;
          r.id   = id_acc;
          if (stop_pos == 3'd4) r.verb = VERB_STOP;
          else if (start_pos == 3'd5) r.verb = VERB_START;
          else r.verb = VERB_OTHER;
        end else begin
          r.kind = KIND_PREFIX;
        end
        awaited_reports.push_back(r);
      end
      new_line();
      return;
    end
    // Reject unprintable bytes and anything past a full line, even while dropping
    if (b < PRINT_LOW || b > PRINT_HIGH || stored_len >= LINE_BYTES - 1) begin
      drop_rest = 1'b1;
      r.kind    = KIND_BYTE;
      awaited_reports.push_back(r);
      return;
    end
    if (drop_rest) return;
    if (stored_len < 5) begin
      if (b != tag_byte(stored_len)) tag_ok = 1'b0;
    end else if (stored_len < 13) begin
      v = hex_digit(b);
      if (v < 0) tag_ok = 1'b0;
      else id_acc = {id_acc[27:0], v[3:0]};
    end else if (stored_len == 13) begin
      if (b != SPACE) tag_ok = 1'b0;
    end else begin
      k = stored_len - VERB_POS;
      stop_pos  = (int'(stop_pos) == k && k < 4 && b == STOP_TEXT[k]) ?
                  3'(k + 1) : MATCH_DEAD;
      start_pos = (int'(start_pos) == k && k < 5 && b == START_TEXT[k]) ?
                  3'(k + 1) : MATCH_DEAD;
    end
    stored_len++;
  endtask

  always @(posedge clk) begin
    line_report_t got;
    line_report_t want;
    if (!rst_n) begin
      awaited_reports.delete();
      mismatches = 0;
      new_line();
    end else begin
      if (out_valid && !out_stall) begin
        got = '{out_report_kind, out_verb_class, out_request_id, out_line_length};
        if (awaited_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected report: kind %0d verb %0d id %h len %0d",
                     got.kind, got.verb, got.id, got.len);
        end else begin
          want = awaited_reports.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"report mismatch: expected kind %0d verb %0d id %h len %0d,",
                        " got kind %0d verb %0d id %h len %0d"},
                       want.kind, want.verb, want.id, want.len,
                       got.kind, got.verb, got.id, got.len);
          end
        end
      end
      if (in_valid && !in_stall) frame_byte(in_rx_byte);
    end
    fail_count      <= mismatches;
    pending_reports <= awaited_reports.size();
  end

endmodule

// File: verif/command_line_framer_test.sv
// Stimulus and verdict for the command line framer.
`timescale 1ns / 1ps

module command_line_framer_test;
  import clf_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_report_kind;
  logic [1:0]  out_verb_class;
  logic [31:0] out_request_id;
  logic [7:0]  out_line_length;

  int fail_count;
  int pending_reports;
  int cycle_count   = 0;
  int byte_count    = 0;
  int gap_pct       = 0;
  int stall_pct     = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;

  logic [7:0] line_bytes[$];

  command_line_framer DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_report_kind (out_report_kind),
    .out_verb_class  (out_verb_class),
    .out_request_id  (out_request_id),
    .out_line_length (out_line_length)
  );

  line_report_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_report_kind (out_report_kind),
    .out_verb_class  (out_verb_class),
    .out_request_id  (out_request_id),
    .out_line_length (out_line_length),
    .fail_count      (fail_count),
    .pending_reports (pending_reports)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL command_line_framer");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    while (gap < 30 && $urandom_range(0, 99) < gap_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (b != CHAR_CR) byte_count++;
  endtask

  task automatic send_line();
    foreach (line_bytes[i]) send_byte(line_bytes[i]);
    line_bytes.delete();
  endtask

  // Hold the sender until every report is in, then let the pipeline settle
  task automatic wait_quiet();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_reports != 0);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
  endtask

  task automatic add_tag();
    line_bytes.push_back(8'h41);
    line_bytes.push_back(8'h30);
    line_bytes.push_back(8'h34);
    line_bytes.push_back(8'h42);
    line_bytes.push_back(8'h20);
  endtask

  // Tag, eight hex digits of mixed case, space
  task automatic add_header();
    int mode;
    int v;
    mode = $urandom_range(0, 7);
    add_tag();
    for (int i = 0; i < 8; i++) begin
      v = (mode == 0) ? 0 : (mode == 1) ? 15 : $urandom_range(0, 15);
      if (v < 10) line_bytes.push_back(8'h30 + 8'(v));
      else if ($urandom_range(0, 1)) line_bytes.push_back(8'h41 + 8'(v - 10));
      else line_bytes.push_back(8'h61 + 8'(v - 10));
    end
    line_bytes.push_back(8'h20);
  endtask

  task automatic add_verb();
    int n;
    case ($urandom_range(0, 9))
      0, 1: add_text("STOP");
      2, 3: add_text("START");
      4: add_text("STO");
      5: add_text("STARTS");
      6: add_text("stop");
      7: add_text("STOPX");
      8: add_text("S");
      default: begin
        n = $urandom_range(1, 12);
        repeat (n) line_bytes.push_back(8'($urandom_range(32, 126)));
      end
    endcase
  endtask

  function automatic logic [7:0] bad_byte();
    logic [7:0] b;
    if ($urandom_range(0, 1)) return 8'($urandom_range(127, 255));
    do b = 8'($urandom_range(0, 31)); while (b == CHAR_LF || b == CHAR_CR);
    return b;
  endfunction

  task automatic make_random_line();
    int sel;
    int keep;
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      add_header();
      add_verb();
    end else if (sel < 70) begin
      add_header();
      add_verb();
      if ($urandom_range(0, 1)) begin
        line_bytes[$urandom_range(0, 13)] = 8'($urandom_range(32, 126));
      end else begin
        keep = $urandom_range(0, 14);
        while (line_bytes.size() > keep) void'(line_bytes.pop_back());
      end
    end else if (sel < 80) begin
      add_header();
      add_verb();
      line_bytes.insert($urandom_range(0, line_bytes.size()), bad_byte());
      if ($urandom_range(0, 1)) begin
        add_text("Zq");
        line_bytes.push_back(bad_byte());
      end
    end else if (sel < 92) begin
      repeat ($urandom_range(1, 16)) line_bytes.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 3) == 0)
      line_bytes.insert($urandom_range(0, line_bytes.size()), CHAR_CR);
    line_bytes.push_back(CHAR_LF);
    send_line();
  endtask

  // Header plus printable filler up to a full line of stored characters
  task automatic fill_line();
    add_header();
    while (line_bytes.size() < LINE_BYTES_DEFAULT - 1)
      line_bytes.push_back(8'($urandom_range(32, 126)));
  endtask

  initial begin
    int ph;
    int phase_start;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_rx_byte = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: byte extremes, stray newline while dropping, short line, good STOP line
    line_bytes = '{8'h00, 8'hFF, 8'h7F, CHAR_CR, CHAR_LF, 8'h20, 8'h7E, CHAR_LF};
    send_line();
    add_tag();
    add_text("0123aBcD STOP");
    line_bytes.push_back(CHAR_LF);
    send_line();
    wait_quiet();

    // Full-length line accepted, then one that overflows and is dropped
    fill_line();
    line_bytes.push_back(CHAR_LF);
    send_line();
    fill_line();
    add_text("xyz");
    line_bytes.push_back(CHAR_CR);
    line_bytes.push_back(bad_byte());
    add_text("q");
    line_bytes.push_back(CHAR_LF);
    send_line();
    wait_quiet();

    // Long receiver hold-off while the sender keeps offering good lines
    hold_requests <= hold_requests + 1;
    repeat (6) begin
      add_header();
      add_verb();
      line_bytes.push_back(CHAR_LF);
      send_line();
    end
    wait_quiet();

    ph = 0;
    while (ph < 4) begin
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct <= 0;  end
        1: begin gap_pct = 72; stall_pct <= 0;  end
        2: begin gap_pct = 0;  stall_pct <= 72; end
        default: begin gap_pct = 23; stall_pct <= 23; end
      endcase
      phase_start = byte_count;
      while (byte_count - phase_start < 25) make_random_line();
      wait_quiet();
      ph++;
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_reports == 0) begin
      $display("PASS command_line_framer");
    end else begin
      $display("FAIL command_line_framer");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/clf_pkg.sv
sv/clf_front.sv
sv/clf_queue.sv
sv/clf_back.sv
sv/command_line_framer.sv
verif/line_report_checker.sv
verif/command_line_framer_test.sv
